// ----- sv/kvrm_pkg.sv -----
// Shared types and constants for the key/velocity region matcher.
package kvrm_pkg;

  localparam int unsigned MaxRegions = 64;
  localparam int unsigned IdxW       = $clog2(MaxRegions);
  localparam int unsigned CntW       = $clog2(MaxRegions + 1);
  localparam int unsigned ValW       = 7;
  localparam int unsigned SrcW       = 16;

  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [ValW-1:0] key_lo;
    logic [ValW-1:0] key_hi;
    logic [ValW-1:0] vel_lo;
    logic [ValW-1:0] vel_hi;
    logic [SrcW-1:0] src;
    logic            is_gen;
  } region_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [SrcW-1:0] src;
    logic            is_gen;
    logic [CntW-1:0] cnt;
  } pend_t;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
    logic [SrcW-1:0] src;
    logic            is_gen;
    logic [CntW-1:0] cnt;
    logic            full;
    logic            last;
  } result_t;

endpackage

// ----- sv/kvrm_cell.sv -----
// One ring cell holding a single stored region.
module kvrm_cell (
  input  logic                clk_i,
  input  kvrm_pkg::cell_ctrl_t ctrl_i,
  input  kvrm_pkg::region_t   wr_i,
  input  kvrm_pkg::region_t   nbr_i,
  output kvrm_pkg::region_t   region_o
);
  import kvrm_pkg::*;

  region_t region_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      region_q <= wr_i;
    end else if (ctrl_i.shift) begin
      region_q <= nbr_i;
    end
  end

  assign region_o = region_q;

endmodule

// ----- sv/key_velocity_region_matcher_top.sv -----
// Top level of the key/velocity region matcher: region ring, walk control, result register.
//
// An add's result word appears on the cycle after start and the block is ready again at
// once. A query holds busy through the walk and flush states: the stored regions sit in a
// ring of 64 cells that rotates one place per cycle past a single comparator, so every
// query makes one full turn of the ring, then the flush state emits the final word with
// any last match. Matches come out one word per cycle at most, each in the cycle after
// the next match is found; an item's final word carries last_o. The receiver cannot stall.
module key_velocity_region_matcher_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd_i,
  input  logic [kvrm_pkg::ValW-1:0]       note_key_i,
  input  logic [kvrm_pkg::ValW-1:0]       note_velocity_i,
  input  logic [kvrm_pkg::ValW-1:0]       key_low_i,
  input  logic [kvrm_pkg::ValW-1:0]       key_high_i,
  input  logic [kvrm_pkg::ValW-1:0]       vel_low_i,
  input  logic [kvrm_pkg::ValW-1:0]       vel_high_i,
  input  logic [kvrm_pkg::SrcW-1:0]       source_ref_i,
  input  logic                            source_is_generator_i,
  output logic                            result_valid_o,
  output logic                            hit_o,
  output logic [kvrm_pkg::IdxW-1:0]       region_index_o,
  output logic [kvrm_pkg::SrcW-1:0]       out_source_ref_o,
  output logic                            out_is_generator_o,
  output logic [kvrm_pkg::CntW-1:0]       match_count_o,
  output logic                            table_full_o,
  output logic                            last_o
);
  import kvrm_pkg::*;

  localparam logic [IdxW-1:0] LastPos = IdxW'(MaxRegions - 1);
  localparam logic [CntW-1:0] Full    = CntW'(MaxRegions);

  state_e          state_q, state_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [CntW-1:0] count_q, count_d;
  logic [ValW-1:0] key_q, key_d;
  logic [ValW-1:0] vel_q, vel_d;
  logic [CntW-1:0] n_q, n_d;
  logic            pend_valid_q, pend_valid_d;
  pend_t           pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;
  logic            shift;
  logic            load;
  logic            match;
  region_t         wr;
  region_t         ring [MaxRegions];

  assign wr = '{key_lo: key_low_i, key_hi: key_high_i, vel_lo: vel_low_i,
                vel_hi: vel_high_i, src: source_ref_i, is_gen: source_is_generator_i};

  for (genvar i = 0; i < MaxRegions; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.shift = shift;
    assign ctrl.load  = load && (count_q[IdxW-1:0] == IdxW'(i));
    kvrm_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .wr_i    (wr),
      .nbr_i   (ring[(i + 1) % MaxRegions]),
      .region_o(ring[i])
    );
  end

  assign match = ({1'b0, pos_q} < count_q) &&
                 (key_q >= ring[0].key_lo) && (key_q <= ring[0].key_hi) &&
                 (vel_q >= ring[0].vel_lo) && (vel_q <= ring[0].vel_hi);

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    count_d      = count_q;
    key_d        = key_q;
    vel_d        = vel_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = 1'b0;
    out_d        = out_q;
    shift        = 1'b0;
    load         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == CmdAdd) begin
            out_valid_d = 1'b1;
            if (count_q >= Full) begin
              out_d = '{hit: 1'b0, idx: '0, src: '0, is_gen: 1'b0, cnt: '0,
                        full: 1'b1, last: 1'b1};
            end else begin
              out_d = '{hit: 1'b1, idx: count_q[IdxW-1:0], src: source_ref_i,
                        is_gen: source_is_generator_i, cnt: '0, full: 1'b0, last: 1'b1};
              load    = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end else begin
            key_d        = note_key_i;
            vel_d        = note_velocity_i;
            pos_d        = '0;
            n_d          = '0;
            pend_valid_d = 1'b0;
            state_d      = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        shift = 1'b1;
        if (match) begin
          n_d          = n_q + CntW'(1);
          pend_d       = '{idx: pos_q, src: ring[0].src, is_gen: ring[0].is_gen,
                           cnt: n_q + CntW'(1)};
          pend_valid_d = 1'b1;
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d = '{hit: 1'b1, idx: pend_q.idx, src: pend_q.src, is_gen: pend_q.is_gen,
                      cnt: pend_q.cnt, full: 1'b0, last: 1'b0};
          end
        end
        if (pos_q == LastPos) begin
          state_d = ST_FLUSH;
        end else begin
          pos_d = pos_q + IdxW'(1);
        end
      end
      ST_FLUSH: begin
        out_valid_d = 1'b1;
        if (pend_valid_q) begin
          out_d = '{hit: 1'b1, idx: pend_q.idx, src: pend_q.src, is_gen: pend_q.is_gen,
                    cnt: pend_q.cnt, full: 1'b0, last: 1'b1};
        end else begin
          out_d = '{hit: 1'b0, idx: '0, src: '0, is_gen: 1'b0, cnt: '0,
                    full: 1'b0, last: 1'b1};
        end
        pend_valid_d = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      count_q      <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      count_q      <= count_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    vel_q  <= vel_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign busy               = (state_q != ST_IDLE);
  assign result_valid_o     = out_valid_q;
  assign hit_o              = out_q.hit;
  assign region_index_o     = out_q.idx;
  assign out_source_ref_o   = out_q.src;
  assign out_is_generator_o = out_q.is_gen;
  assign match_count_o      = out_q.cnt;
  assign table_full_o       = out_q.full;
  assign last_o             = out_q.last;

  a_nonlast_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> hit_o)
    else $error("non-final word without a hit");

  a_full_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && table_full_o) |-> (!hit_o && last_o))
    else $error("table-full word carries a hit");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("region count beyond table size");

  a_flush_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |=> (result_valid_o && last_o))
    else $error("query ended without a final word");

endmodule
